@@ hdl/pprm_pkg.sv @@
package pprm_pkg;

    // Field and state widths
    localparam int SAMPLE_W  = 16;
    localparam int RAW_W     = 10;
    localparam int PERIOD_W  = 10;
    localparam int GAIN_W    = 10;
    localparam int TOL_W     = 12;
    localparam int LEVEL_W   = 20;
    localparam int BPM_W     = 8;
    localparam int ELAPSED_W = 16;

    // Shared divider sizing: dividend constants fit in 16 bits, divisor is the period or elapsed time
    localparam int DVD_W = 16;
    localparam int DIV_W = (ELAPSED_W > DVD_W) ? ELAPSED_W : DVD_W;
    localparam int CNT_W = $clog2(DIV_W);

    // Reciprocal of 5: floor(4a/5) == (a * RECIP_FIVE) >> RECIP_SHIFT for a < 2^20
    localparam int RECIP_W     = 23;
    localparam int RECIP_SHIFT = 23;
    localparam logic [RECIP_W-1:0] RECIP_FIVE = 23'd6710887;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd60;
    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 10'd16;   // 1000 / 60
    localparam logic [TOL_W-1:0]    TOL_RESET    = 12'd50;   // 3000 / 60

    localparam logic [DVD_W-1:0] GAIN_NUM = 16'd1000;
    localparam logic [DVD_W-1:0] TOL_NUM  = 16'd3000;
    localparam logic [DVD_W-1:0] RATE_NUM = 16'd60000;

    localparam logic [DIV_W-1:0] RATE_LO = DIV_W'(50);
    localparam logic [DIV_W-1:0] RATE_HI = DIV_W'(200);

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_GAIN,
        S_TOL,
        S_MUL,
        S_SCALE,
        S_SEL,
        S_PEAK,
        S_RATE,
        S_OUT
    } state_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

@@ hdl/pprm_if.sv @@
// Sample channel
interface pprm_in_if;
    logic                          valid;
    logic                          ready;
    logic [pprm_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// Result channel
interface pprm_out_if;
    logic                       valid;
    logic                       ready;
    logic                       beat;
    logic                       rate_valid;
    logic [pprm_pkg::BPM_W-1:0] rate_bpm;

    modport source (output valid, output beat, output rate_valid, output rate_bpm,
                    input ready);
    modport sink   (input valid, input beat, input rate_valid, input rate_bpm,
                    output ready);
endinterface

@@ hdl/pulse_peak_rate_meter.sv @@
// Pulse peak detector with beats-per-minute readout.
// in_ch carries one 16-bit converter sample per transfer; out_ch returns one result
// per sample: beat flag, rate_valid and rate_bpm (0 unless rate_valid).
// cfg_wr_en/cfg_wr_data write sample_period_ms; a value of 0 acts as 1.
// After a period write the block derives gain = 1000/p and tolerance = 3000/p
// with the shared serial divider, with in_ch.ready low.
// Per sample: acceptance leads through S_MUL, S_SCALE, S_SEL, S_PEAK and S_OUT
// to the result; on a beat with nonzero elapsed time S_RATE runs 60000/elapsed
// through the same divider at one quotient bit per cycle (16 bits). The block holds one sample
// at a time; in_ch.ready is high only while idle, so a new sample is taken
// only after the previous result has gone to the output register.
// Results sit in an output register; if out_ch stalls, the next finished result
// waits and the block stays in its last step until the register frees.
// Reset (rst_n, async, active low) sets the period to 60 ms, gain 16,
// tolerance 50, and clears the peak level, peak-zone flag, elapsed time and
// the output valid flag.
module pulse_peak_rate_meter
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [pprm_pkg::PERIOD_W-1:0] cfg_wr_data,
    pprm_in_if.sink                       in_ch,
    pprm_out_if.source                    out_ch
);

    localparam int PROD_W = pprm_pkg::LEVEL_W + pprm_pkg::RECIP_W;

    pprm_pkg::state_t state_reg, state_next;

    logic [pprm_pkg::PERIOD_W-1:0]  period_reg;
    logic                           dirty_reg;
    logic [pprm_pkg::GAIN_W-1:0]    gain_reg, gain_next;
    logic [pprm_pkg::TOL_W-1:0]     tol_reg, tol_next;
    logic [pprm_pkg::RAW_W-1:0]     raw_reg, raw_next;
    logic [pprm_pkg::LEVEL_W-1:0]   a_reg, a_next;
    logic [pprm_pkg::LEVEL_W-1:0]   q5_reg, q5_next;
    logic [pprm_pkg::LEVEL_W-1:0]   peak_reg, peak_next;
    logic                           in_peak_reg, in_peak_next;
    logic [pprm_pkg::ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic                           beat_reg, beat_next;
    logic                           ok_reg, ok_next;
    logic [pprm_pkg::BPM_W-1:0]     bpm_reg, bpm_next;

    logic                           ov_reg, ov_next;
    logic                           ob_reg, ob_next;
    logic                           orv_reg, orv_next;
    logic [pprm_pkg::BPM_W-1:0]     obpm_reg, obpm_next;

    pprm_pkg::div_req_t div_req;
    pprm_pkg::div_rsp_t div_rsp;

    logic [pprm_pkg::PERIOD_W-1:0]  p_eff;
    logic [PROD_W-1:0]              prod;
    logic [pprm_pkg::LEVEL_W:0]     a_plus_gain;
    logic [pprm_pkg::LEVEL_W:0]     a_plus_tol;
    logic                           enter_zone;
    logic                           leave_zone;
    logic [pprm_pkg::ELAPSED_W-1:0] el_base;
    logic [pprm_pkg::ELAPSED_W:0]   el_sum;
    logic                           out_free;
    logic                           rate_in_range;

    pprm_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Zero period acts as one
    assign p_eff = (period_reg == '0) ? pprm_pkg::PERIOD_W'(1) : period_reg;

    // Datapath helpers
    assign prod        = PROD_W'(a_reg) * PROD_W'(pprm_pkg::RECIP_FIVE);
    assign a_plus_gain = {1'b0, a_reg} + (pprm_pkg::LEVEL_W + 1)'(gain_reg);
    assign a_plus_tol  = {1'b0, a_reg} + (pprm_pkg::LEVEL_W + 1)'(tol_reg);
    assign enter_zone  = a_plus_gain > {1'b0, peak_reg};
    assign leave_zone  = a_plus_tol < {1'b0, peak_reg};
    assign el_base     = beat_reg ? '0 : elapsed_reg;
    assign el_sum      = {1'b0, el_base} + (pprm_pkg::ELAPSED_W + 1)'(p_eff);
    assign out_free    = !ov_reg || out_ch.ready;
    assign rate_in_range = (div_rsp.quotient > pprm_pkg::RATE_LO) &&
                           (div_rsp.quotient < pprm_pkg::RATE_HI);

    assign in_ch.ready = (state_reg == pprm_pkg::S_IDLE) && !dirty_reg && !cfg_wr_en;

    // Sequencer and datapath next values
    always_comb
    begin
        state_next   = state_reg;
        gain_next    = gain_reg;
        tol_next     = tol_reg;
        raw_next     = raw_reg;
        a_next       = a_reg;
        q5_next      = q5_reg;
        peak_next    = peak_reg;
        in_peak_next = in_peak_reg;
        elapsed_next = elapsed_reg;
        beat_next    = beat_reg;
        ok_next      = ok_reg;
        bpm_next     = bpm_reg;
        ov_next      = ov_reg && !out_ch.ready;
        ob_next      = ob_reg;
        orv_next     = orv_reg;
        obpm_next    = obpm_reg;
        div_req.start    = 1'b0;
        div_req.dividend = pprm_pkg::DIV_W'(pprm_pkg::GAIN_NUM);
        div_req.divisor  = pprm_pkg::DIV_W'(p_eff);

        case (state_reg)
            pprm_pkg::S_IDLE:
            begin
                if (dirty_reg)
                begin
                    div_req.start = 1'b1;
                    state_next    = pprm_pkg::S_GAIN;
                end
                else if (in_ch.valid && in_ch.ready)
                begin
                    raw_next   = in_ch.sample[pprm_pkg::SAMPLE_W-1 -: pprm_pkg::RAW_W];
                    state_next = pprm_pkg::S_MUL;
                end
            end

            pprm_pkg::S_GAIN:
            begin
                if (div_rsp.done)
                begin
                    gain_next        = div_rsp.quotient[pprm_pkg::GAIN_W-1:0];
                    div_req.start    = 1'b1;
                    div_req.dividend = pprm_pkg::DIV_W'(pprm_pkg::TOL_NUM);
                    state_next       = pprm_pkg::S_TOL;
                end
            end

            pprm_pkg::S_TOL:
            begin
                if (div_rsp.done)
                begin
                    tol_next   = div_rsp.quotient[pprm_pkg::TOL_W-1:0];
                    state_next = pprm_pkg::S_IDLE;
                end
            end

            // Scaled sample
            pprm_pkg::S_MUL:
            begin
                a_next     = pprm_pkg::LEVEL_W'(raw_reg) * pprm_pkg::LEVEL_W'(gain_reg);
                state_next = pprm_pkg::S_SCALE;
            end

            // 4a/5 by reciprocal
            pprm_pkg::S_SCALE:
            begin
                q5_next    = prod[pprm_pkg::RECIP_SHIFT +: pprm_pkg::LEVEL_W];
                state_next = pprm_pkg::S_SEL;
            end

            // Peak collapses when the sample falls below a quarter of it
            pprm_pkg::S_SEL:
            begin
                if ({a_reg, 2'b00} < {2'b00, peak_reg})
                    peak_next = q5_reg;
                state_next = pprm_pkg::S_PEAK;
            end

            // Peak zone tracking and beat detection
            pprm_pkg::S_PEAK:
            begin
                beat_next  = 1'b0;
                ok_next    = 1'b0;
                bpm_next   = '0;
                state_next = pprm_pkg::S_OUT;
                if (enter_zone)
                begin
                    if (a_reg > peak_reg)
                        peak_next = a_reg;
                    beat_next    = !in_peak_reg;
                    in_peak_next = 1'b1;
                    if (!in_peak_reg && (elapsed_reg != '0))
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = pprm_pkg::DIV_W'(pprm_pkg::RATE_NUM);
                        div_req.divisor  = pprm_pkg::DIV_W'(elapsed_reg);
                        state_next       = pprm_pkg::S_RATE;
                    end
                end
                else if (leave_zone)
                begin
                    in_peak_next = 1'b0;
                    peak_next    = (peak_reg >= pprm_pkg::LEVEL_W'(gain_reg)) ?
                                   peak_reg - pprm_pkg::LEVEL_W'(gain_reg) : '0;
                end
            end

            pprm_pkg::S_RATE:
            begin
                if (div_rsp.done)
                begin
                    ok_next    = rate_in_range;
                    bpm_next   = rate_in_range ?
                                 div_rsp.quotient[pprm_pkg::BPM_W-1:0] : '0;
                    state_next = pprm_pkg::S_OUT;
                end
            end

            // Hand result to the output register, advance elapsed time
            pprm_pkg::S_OUT:
            begin
                if (out_free)
                begin
                    ov_next      = 1'b1;
                    ob_next      = beat_reg;
                    orv_next     = ok_reg;
                    obpm_next    = bpm_reg;
                    elapsed_next = el_sum[pprm_pkg::ELAPSED_W] ? pprm_pkg::ELAPSED_MAX :
                                   el_sum[pprm_pkg::ELAPSED_W-1:0];
                    state_next   = pprm_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = pprm_pkg::S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= pprm_pkg::S_IDLE;
            period_reg  <= pprm_pkg::PERIOD_RESET;
            dirty_reg   <= 1'b0;
            gain_reg    <= pprm_pkg::GAIN_RESET;
            tol_reg     <= pprm_pkg::TOL_RESET;
            peak_reg    <= '0;
            in_peak_reg <= 1'b0;
            elapsed_reg <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            gain_reg    <= gain_next;
            tol_reg     <= tol_next;
            peak_reg    <= peak_next;
            in_peak_reg <= in_peak_next;
            elapsed_reg <= elapsed_next;
            ov_reg      <= ov_next;
            if (cfg_wr_en)
            begin
                period_reg <= cfg_wr_data;
                dirty_reg  <= 1'b1;
            end
            else if (state_reg == pprm_pkg::S_IDLE)
            begin
                dirty_reg  <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        raw_reg  <= raw_next;
        a_reg    <= a_next;
        q5_reg   <= q5_next;
        beat_reg <= beat_next;
        ok_reg   <= ok_next;
        bpm_reg  <= bpm_next;
        ob_reg   <= ob_next;
        orv_reg  <= orv_next;
        obpm_reg <= obpm_next;
    end

    assign out_ch.valid      = ov_reg;
    assign out_ch.beat       = ob_reg;
    assign out_ch.rate_valid = orv_reg;
    assign out_ch.rate_bpm   = obpm_reg;

endmodule

@@ hdl/pprm_div.sv @@
// Restoring divider, one quotient bit per cycle
module pprm_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  pprm_pkg::div_req_t req,
    output pprm_pkg::div_rsp_t rsp
);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [pprm_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [pprm_pkg::DIV_W:0]       rem_reg, rem_next;
    logic [pprm_pkg::DIV_W-1:0]     quo_reg, quo_next;
    logic [pprm_pkg::DIV_W-1:0]     dsr_reg, dsr_next;
    logic [pprm_pkg::DIV_W:0]       rem_sh;
    logic [pprm_pkg::DIV_W:0]       rem_sub;
    logic                           q_bit;

    // One shift-subtract step
    always_comb
    begin
        rem_sh  = {rem_reg[pprm_pkg::DIV_W-1:0], quo_reg[pprm_pkg::DIV_W-1]};
        q_bit   = (rem_sh >= {1'b0, dsr_reg});
        rem_sub = rem_sh - {1'b0, dsr_reg};
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = q_bit ? rem_sub : rem_sh;
            quo_next = {quo_reg[pprm_pkg::DIV_W-2:0], q_bit};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == pprm_pkg::CNT_W'(pprm_pkg::DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule
